// ===== hw/rtl/krst_pkg.sv =====
// ----------------------------------------------------------------------------
// krst_pkg: shared definitions for the keyed record slot table
// Table size, operation and status codes, controller/datapath command and
// status structures, and the name length and normalisation functions.
// ----------------------------------------------------------------------------
`default_nettype none

package krst_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int NAME_BYTES = 10;
    localparam int NAME_W     = 8 * NAME_BYTES;

    // Operation codes carried by a request.
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Status codes carried by a result.
    localparam logic [1:0] ST_MISS   = 2'd0;
    localparam logic [1:0] ST_HIT    = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic start;     // capture the request payload
        logic scan;      // step the slot scan
        logic rd_idx;    // read the slot named by the request index
        logic write;     // commit an insert or update
        logic load_out;  // load the result register
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;        // captured operation
        logic       hit_now;   // the slot under comparison matches
        logic       exhausted; // every slot has been compared
    } t_sts;

    // Position of the first zero byte, or the full name length.
    function automatic logic [3:0] name_len(input logic [NAME_W-1:0] nm);
        logic       found;
        logic [3:0] len;
        found = 1'b0;
        len   = 4'(NAME_BYTES);
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (!found && (nm[8*k +: 8] == 8'd0)) begin
                found = 1'b1;
                len   = 4'(k);
            end
        end
        return len;
    endfunction

    // Clear every byte after the first zero byte.
    function automatic logic [NAME_W-1:0] normalise(input logic [NAME_W-1:0] nm);
        logic [3:0]        len;
        logic [NAME_W-1:0] res;
        len = name_len(nm);
        res = '0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            res[8*k +: 8] = (4'(k) < len) ? nm[8*k +: 8] : 8'd0;
        end
        return res;
    endfunction

    // Slot number as shown on the result: its low three bits.
    function automatic logic [2:0] slot_to_out(input logic [SLOT_W-1:0] s);
        logic [31:0] t;
        t = 32'(s);
        return t[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/krst_if.sv =====
// ----------------------------------------------------------------------------
// krst_if: request and result channels of the keyed record slot table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface krst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [2:0]  slot_index;
    logic [63:0] name_head;
    logic [15:0] name_tail;
    logic [15:0] money;

    modport source (output valid, operation, slot_index, name_head, name_tail, money,
                    input ready);
    modport sink   (input valid, operation, slot_index, name_head, name_tail, money,
                    output ready);
endinterface

interface krst_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  slot_found;
    logic [63:0] stored_name_head;
    logic [15:0] stored_name_tail;
    logic [3:0]  name_length;
    logic [15:0] stored_money;

    modport source (output valid, status, slot_found, stored_name_head, stored_name_tail,
                    name_length, stored_money, input ready);
    modport sink   (input valid, status, slot_found, stored_name_head, stored_name_tail,
                    name_length, stored_money, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/keyed_record_slot_table.sv =====
// ----------------------------------------------------------------------------
// keyed_record_slot_table: insert-or-update table of named money records
// Eight slots keyed by a ten-byte name; lookup, insert-or-update and read
// by slot index, one request at a time.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   i_req    in         operation, slot_index, name_head, name_tail, money
//   o_rsp    out        status, slot_found, stored name, name_length, money
//
// A lookup or write scans the slots through the single memory read port,
// one slot per cycle, each compared in the cycle after its read; the scan
// stops at the first match or once every slot has been compared. A read by
// index reads the named slot alone, and the unused operation code goes
// straight to the result.
// Reset is synchronous and active low; it empties the table by clearing
// the valid bits.
// A new request is taken as soon as the previous result sits in the output
// register; a stalled result only holds the next one back at its last step.
//
`default_nettype none

module keyed_record_slot_table
    import krst_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    krst_req_if.sink   i_req,
    krst_rsp_if.source o_rsp
);

    // The controller and the datapath talk only through these two groups.
    t_cmd cmd;
    t_sts sts;

    logic in_ready;
    logic out_valid;

    krst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the request, the slot memories and the result
    // register; its payload goes straight onto the result channel.
    krst_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_operation        (i_req.operation),
        .i_slot_index       (i_req.slot_index),
        .i_name_head        (i_req.name_head),
        .i_name_tail        (i_req.name_tail),
        .i_money            (i_req.money),
        .o_status           (o_rsp.status),
        .o_slot_found       (o_rsp.slot_found),
        .o_stored_name_head (o_rsp.stored_name_head),
        .o_stored_name_tail (o_rsp.stored_name_tail),
        .o_name_length      (o_rsp.name_length),
        .o_stored_money     (o_rsp.stored_money)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/krst_ctrl.sv =====
// ----------------------------------------------------------------------------
// krst_ctrl: sequencer of the keyed record slot table
// Accepts a request, steps the datapath through scan, read or write, and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module krst_ctrl
    import krst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DISP  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_RDIDX = 6'b001000,
        S_WRITE = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    // No request is taken while reset is held.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.op)
                    OP_LOOKUP: n_state = S_SCAN;
                    OP_WRITE:  n_state = S_SCAN;
                    OP_READ:   n_state = S_RDIDX;
                    default:   n_state = S_RESP;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit_now || i_sts.exhausted) begin
                    n_state = (i_sts.op == OP_WRITE) ? S_WRITE : S_RESP;
                end
            end
            S_RDIDX: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_RESP;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/krst_dp.sv =====
// ----------------------------------------------------------------------------
// krst_dp: datapath of the keyed record slot table
// Request registers, slot memories with a registered read port, valid bits,
// the scan counter with its comparator, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module krst_dp
    import krst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [1:0]  i_operation,
    input  wire logic [2:0]  i_slot_index,
    input  wire logic [63:0] i_name_head,
    input  wire logic [15:0] i_name_tail,
    input  wire logic [15:0] i_money,
    output logic [1:0]       o_status,
    output logic [2:0]       o_slot_found,
    output logic [63:0]      o_stored_name_head,
    output logic [15:0]      o_stored_name_tail,
    output logic [3:0]       o_name_length,
    output logic [15:0]      o_stored_money
);

    // Slot storage; contents are only meaningful where the valid bit is set.
    logic [63:0] mem_head  [SLOTS];
    logic [15:0] mem_tail  [SLOTS];
    logic [15:0] mem_money [SLOTS];
    logic [SLOTS-1:0] r_valid;

    // Captured request, name already normalised.
    logic [1:0]  r_op;
    logic [2:0]  r_idx;
    logic [63:0] r_head;
    logic [15:0] r_tail;
    logic [15:0] r_money;

    // Scan state.
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_live;
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_free_ok;
    logic [SLOT_W-1:0] r_free_slot;

    // Registered read port.
    logic [63:0]       r_rd_head;
    logic [15:0]       r_rd_tail;
    logic [15:0]       r_rd_money;
    logic [SLOT_W-1:0] r_rd_slot;

    logic              hit_now, issue, rd_en, wr_en, wr_ok, idx_ok, idx_valid;
    logic [SLOT_W-1:0] rd_addr, idx_addr, wr_slot, cnt_addr;
    logic [NAME_W-1:0] norm_name;

    logic [1:0]  n_status;
    logic [2:0]  n_slot;
    logic [63:0] n_head;
    logic [15:0] n_tail;
    logic [3:0]  n_len;
    logic [15:0] n_money;

    assign norm_name = normalise({i_name_tail, i_name_head});
    assign cnt_addr  = r_cnt[SLOT_W-1:0];
    assign hit_now   = r_rd_live && r_valid[r_rd_slot]
                       && (r_rd_head == r_head) && (r_rd_tail == r_tail);
    // Stop reading once a match appears so the read registers keep it.
    assign issue     = i_cmd.scan && (32'(r_cnt) < SLOTS) && !hit_now;
    assign idx_addr  = SLOT_W'(r_idx);
    assign idx_ok    = (32'(r_idx) < SLOTS);
    assign idx_valid = idx_ok && r_valid[idx_addr];
    assign rd_en     = issue || i_cmd.rd_idx;
    assign rd_addr   = i_cmd.rd_idx ? idx_addr : cnt_addr;
    assign wr_ok     = r_hit || r_free_ok;
    assign wr_slot   = r_hit ? r_hit_slot : r_free_slot;
    assign wr_en     = i_cmd.write && wr_ok;

    assign o_sts.op        = r_op;
    assign o_sts.hit_now   = hit_now;
    assign o_sts.exhausted = (r_cnt == CNT_W'(SLOTS)) && !r_rd_live;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_head  <= mem_head[rd_addr];
            r_rd_tail  <= mem_tail[rd_addr];
            r_rd_money <= mem_money[rd_addr];
            r_rd_slot  <= rd_addr;
        end
        if (wr_en) begin
            mem_head[wr_slot]  <= r_head;
            mem_tail[wr_slot]  <= r_tail;
            mem_money[wr_slot] <= r_money;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_operation;
            r_idx   <= i_slot_index;
            r_head  <= norm_name[63:0];
            r_tail  <= norm_name[NAME_W-1:64];
            r_money <= i_money;
        end
        if (hit_now && i_cmd.scan) begin
            r_hit_slot <= r_rd_slot;
        end
        if (issue && !r_free_ok && !r_valid[cnt_addr]) begin
            r_free_slot <= cnt_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_cnt     <= '0;
            r_rd_live <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.start) begin
            r_cnt     <= '0;
            r_rd_live <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            r_rd_live <= issue;
            if (issue) begin
                r_cnt <= r_cnt + 1'b1;
                if (!r_valid[cnt_addr]) begin
                    r_free_ok <= 1'b1;
                end
            end
            if (hit_now && i_cmd.scan) begin
                r_hit <= 1'b1;
            end
            if (wr_en) begin
                r_valid[wr_slot] <= 1'b1;
            end
        end
    end

    // Result selection from the outcome of the finished operation.
    always_comb begin
        n_status = ST_MISS;
        n_slot   = 3'd0;
        n_head   = '0;
        n_tail   = '0;
        n_len    = '0;
        n_money  = '0;
        case (r_op)
            OP_LOOKUP: begin
                if (r_hit) begin
                    n_status = ST_HIT;
                    n_slot   = slot_to_out(r_rd_slot);
                    n_head   = r_rd_head;
                    n_tail   = r_rd_tail;
                    n_len    = name_len({r_rd_tail, r_rd_head});
                    n_money  = r_rd_money;
                end
            end
            OP_WRITE: begin
                if (wr_ok) begin
                    n_status = r_hit ? ST_HIT : ST_INSERT;
                    n_slot   = slot_to_out(wr_slot);
                    n_head   = r_head;
                    n_tail   = r_tail;
                    n_len    = name_len({r_tail, r_head});
                    n_money  = r_money;
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_READ: begin
                n_slot = r_idx;
                if (idx_valid) begin
                    n_status = ST_HIT;
                    n_head   = r_rd_head;
                    n_tail   = r_rd_tail;
                    n_len    = name_len({r_rd_tail, r_rd_head});
                    n_money  = r_rd_money;
                end
            end
            default: n_status = ST_MISS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status           <= n_status;
            o_slot_found       <= n_slot;
            o_stored_name_head <= n_head;
            o_stored_name_tail <= n_tail;
            o_name_length      <= n_len;
            o_stored_money     <= n_money;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/krst_checker.sv =====
// ----------------------------------------------------------------------------
// krst_checker: port-level checks for the keyed record slot table
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module krst_checker
    import krst_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [2:0]  i_slot_found,
    input wire logic [63:0] i_stored_name_head,
    input wire logic [3:0]  i_name_length,
    input wire logic [15:0] i_stored_money
);

    // A held result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request accepted while one is in progress");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_name_length <= 4'(NAME_BYTES)))
        else $error("name length beyond the name size");

    // A miss or a dropped write shows an empty record.
    a_empty_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_status == ST_MISS) || (i_status == ST_FULL))
        |-> (i_stored_name_head == 64'd0) && (i_name_length == 4'd0)
            && (i_stored_money == 16'd0))
        else $error("record fields set on a miss or dropped write");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_slot_found == 3'd0))
        else $error("slot number set on a dropped write");

endmodule

bind keyed_record_slot_table krst_checker u_krst_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_req.valid),
    .i_in_ready         (i_req.ready),
    .i_out_valid        (o_rsp.valid),
    .i_out_ready        (o_rsp.ready),
    .i_status           (o_rsp.status),
    .i_slot_found       (o_rsp.slot_found),
    .i_stored_name_head (o_rsp.stored_name_head),
    .i_name_length      (o_rsp.name_length),
    .i_stored_money     (o_rsp.stored_money)
);

`default_nettype wire

// ===== tb/tb_keyed_record_slot_table.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_record_slot_table: self-checking bench for the record slot table
// Drives lookups, insert-or-update writes, reads by index and the unused
// operation code through the request channel. A behavioural copy of the table
// predicts every reply, and each reply is compared field by field as it
// leaves the block. Both channels idle and stall at random in several phases.
// ----------------------------------------------------------------------------

module tb_keyed_record_slot_table;

    import krst_pkg::*;

    // The fourth operation code has no name in the package; the block answers it with an empty miss.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  idx;
        logic [79:0] name;
        logic [15:0] amount;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [63:0] head;
        logic [15:0] tail;
        logic [3:0]  len;
        logic [15:0] money;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    krst_req_if req_ch ();
    krst_rsp_if rsp_ch ();

    keyed_record_slot_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Behavioural copy of the table contents. Names are kept already trimmed,
    // that is with every byte after the first zero byte cleared.
    bit          occupied   [SLOTS];
    logic [79:0] key_names  [SLOTS];
    logic [15:0] balances   [SLOTS];

    t_request outgoing[$];       // requests still to be offered to the block
    t_reply   awaited_replies[$]; // predicted replies, oldest first
    t_request next_request;

    int send_idle_pct = 0;
    int hold_pct      = 0;
    int queued_count  = 0;
    int accepted_count = 0;
    int mismatches    = 0;
    int hits          = 0;
    int inserts       = 0;
    int misses        = 0;
    int drops         = 0;

    logic [79:0] known_names [12];

    // ------------------------------------------------------------------------
    // Name helpers. A name is ten bytes with byte 0 in the low bits.
    // ------------------------------------------------------------------------

    // Number of bytes before the first zero byte, or ten if there is none.
    function automatic logic [3:0] count_name_bytes(input logic [79:0] nm);
        for (int k = 0; k < 10; k++) begin
            if (nm[8*k +: 8] == 8'h00) begin
                return 4'(k);
            end
        end
        return 4'd10;
    endfunction

    // Only the bytes in front of the terminator take part in a comparison,
    // so the table stores names with everything behind it cleared.
    function automatic logic [79:0] keep_name_prefix(input logic [79:0] nm);
        logic [79:0] mask;
        logic [3:0]  n;
        mask = '0;
        n    = count_name_bytes(nm);
        for (int k = 0; k < 10; k++) begin
            if (k < n) begin
                mask[8*k +: 8] = 8'hFF;
            end
        end
        return nm & mask;
    endfunction

    // A fresh name of two to ten non-zero bytes, zero-filled behind.
    function automatic logic [79:0] random_key();
        logic [79:0] nm;
        int          n;
        nm = '0;
        n  = $urandom_range(2, 10);
        for (int k = 0; k < n; k++) begin
            nm[8*k +: 8] = 8'($urandom_range(1, 255));
        end
        return nm;
    endfunction

    // Fills the bytes behind the terminator with rubbish, half of the time.
    // The block must ignore them, so the same key appears under many guises.
    function automatic logic [79:0] with_trailing_noise(input logic [79:0] nm);
        logic [79:0] res;
        logic [3:0]  n;
        res = nm;
        n   = count_name_bytes(nm);
        if ($urandom_range(0, 1) == 1) begin
            for (int k = 0; k < 10; k++) begin
                if (k > n) begin
                    res[8*k +: 8] = 8'($urandom);
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Reply prediction
    // ------------------------------------------------------------------------

    function automatic t_reply slot_reply(input logic [1:0] st, input int s);
        t_reply r;
        r.status = st;
        r.slot   = 3'(s);
        r.head   = key_names[s][63:0];
        r.tail   = key_names[s][79:64];
        r.len    = count_name_bytes(key_names[s]);
        r.money  = balances[s];
        return r;
    endfunction

    // Works out the reply to one request and applies any write to the copy of
    // the table. A write that finds its name updates that slot; otherwise it
    // takes the lowest free slot, and on a full table it is dropped.
    function automatic t_reply serve_request(input logic [1:0] op, input logic [2:0] idx,
                                             input logic [79:0] raw,
                                             input logic [15:0] amount);
        t_reply      r;
        logic [79:0] key;
        logic [1:0]  st;
        int          hit;
        int          slot;
        r   = '0;
        key = keep_name_prefix(raw);
        hit = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && occupied[i] && key_names[i] == key) begin
                hit = i;
            end
        end
        case (op)
            OP_LOOKUP: begin
                if (hit >= 0) begin
                    r = slot_reply(ST_HIT, hit);
                end else begin
                    r.status = ST_MISS;
                end
            end
            OP_WRITE: begin
                slot = hit;
                st   = ST_HIT;
                if (slot < 0) begin
                    st = ST_INSERT;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot < 0 && !occupied[i]) begin
                            slot = i;
                        end
                    end
                end
                if (slot >= 0) begin
                    occupied[slot]  = 1'b1;
                    key_names[slot] = key;
                    balances[slot]  = amount;
                    r = slot_reply(st, slot);
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_READ: begin
                if (idx < SLOTS && occupied[idx]) begin
                    r = slot_reply(ST_HIT, idx);
                end else begin
                    r.status = ST_MISS;
                    r.slot   = idx;
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and the request driver
    // ------------------------------------------------------------------------

    // Every input of the block holds a known value from time zero; reset
    // itself is released by the stimulus block.
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_LOOKUP;
        req_ch.slot_index = '0;
        req_ch.name_head  = '0;
        req_ch.name_tail  = '0;
        req_ch.money      = '0;
        rsp_ch.ready      = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // The driver predicts the reply at the very edge where a request is
    // accepted, so the copy of the table moves in step with the block. A new
    // request is offered only once the one on the channel has gone, and the
    // valid line gets at most one assignment per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                awaited_replies.push_back(serve_request(req_ch.operation, req_ch.slot_index,
                                                        {req_ch.name_tail, req_ch.name_head},
                                                        req_ch.money));
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (outgoing.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_request       = outgoing.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.operation  <= next_request.op;
                    req_ch.slot_index <= next_request.idx;
                    req_ch.name_head  <= next_request.name[63:0];
                    req_ch.name_tail  <= next_request.name[79:64];
                    req_ch.money      <= next_request.amount;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Reply monitor
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatches++;
        end
    endtask

    // Each accepted reply is matched against the oldest prediction. The ready
    // line is redrawn every cycle according to the stall rate of the phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply with status %0d arrived with no request outstanding",
                           rsp_ch.status);
                    mismatches++;
                end else begin
                    t_reply want;
                    want = awaited_replies.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("slot_found", want.slot, rsp_ch.slot_found);
                    check_field("stored_name_head", want.head, rsp_ch.stored_name_head);
                    check_field("stored_name_tail", want.tail, rsp_ch.stored_name_tail);
                    check_field("name_length", want.len, rsp_ch.name_length);
                    check_field("stored_money", want.money, rsp_ch.stored_money);
                    case (want.status)
                        ST_HIT:    hits++;
                        ST_INSERT: inserts++;
                        ST_FULL:   drops++;
                        default:   misses++;
                    endcase
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= hold_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_request(input logic [1:0] op, input logic [2:0] idx,
                                 input logic [79:0] nm, input logic [15:0] amount);
        t_request q;
        q.op     = op;
        q.idx    = idx;
        q.name   = nm;
        q.amount = amount;
        outgoing.push_back(q);
        queued_count++;
    endtask

    // Mostly names from the list of known names, so that
    // lookups hit and writes update; now and then a name never seen before.
    function automatic logic [79:0] pick_name();
        if ($urandom_range(0, 99) < 75) begin
            return with_trailing_noise(known_names[$urandom_range(0, 11)]);
        end
        return with_trailing_noise(random_key());
    endfunction

    task automatic queue_random_requests(input int count);
        int          r;
        logic [1:0]  op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 38) begin
                op = OP_LOOKUP;
            end else if (r < 73) begin
                op = OP_WRITE;
            end else if (r < 94) begin
                op = OP_READ;
            end else begin
                op = OP_UNUSED;
            end
            queue_request(op, 3'($urandom), pick_name(), 16'($urandom));
        end
    endtask

    // Waits until every queued request has been taken and answered.
    task automatic wait_for_drain();
        while (accepted_count != queued_count || awaited_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        hold_pct      = stall;
        queue_random_requests(count);
        wait_for_drain();
    endtask

    initial begin
        known_names[0] = '0;                               // the empty name
        known_names[1] = '1;                               // ten bytes, no terminator
        known_names[2] = {16'h0000, 64'h0123456789ABCDEF}; // eight bytes
        known_names[3] = {16'h005A, 64'h8040201008040201}; // nine bytes
        known_names[4] = 80'h7F80FE;                       // three bytes
        for (int k = 5; k < 12; k++) begin
            known_names[k] = random_key();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening: an empty table, each operation, each name length
        // boundary, an update that differs only behind the terminator, the
        // table filling up, a dropped write and the unused operation code.
        queue_request(OP_LOOKUP, 3'd0, known_names[0], 16'h0000);
        queue_request(OP_UNUSED, 3'd7, '1, 16'hFFFF);
        queue_request(OP_WRITE, 3'd0, {16'hFFFF, 64'hFFFF_FFFF_FFFF_FF00}, 16'hFFFF);
        queue_request(OP_LOOKUP, 3'd5, {16'hA5A5, 64'h1234_5678_9ABC_DE00}, 16'h0000);
        queue_request(OP_WRITE, 3'd7, known_names[1], 16'h0000);
        queue_request(OP_WRITE, 3'd0, {16'hC300, known_names[2][63:0]}, 16'h8001);
        queue_request(OP_WRITE, 3'd0, {16'h005A, known_names[3][63:0]}, 16'h7FFE);
        queue_request(OP_WRITE, 3'd0, {16'hFFFF, 64'hFFFF_FFFF_FF7F_80FE}, 16'h1111);
        queue_request(OP_WRITE, 3'd0, {16'h0102, 64'h0304_0506_0000_0000 | 64'h7F80FE},
                      16'h2222);
        queue_request(OP_READ, 3'd4, '1, 16'hFFFF);
        queue_request(OP_LOOKUP, 3'd0, with_trailing_noise(known_names[2]), 16'h0000);
        queue_request(OP_LOOKUP, 3'd0, known_names[8], 16'h0000);
        queue_request(OP_WRITE, 3'd0, known_names[5], 16'h5555);
        queue_request(OP_WRITE, 3'd0, known_names[6], 16'hAAAA);
        queue_request(OP_WRITE, 3'd0, known_names[7], 16'h0F0F);
        queue_request(OP_WRITE, 3'd0, known_names[8], 16'hF0F0);
        queue_request(OP_LOOKUP, 3'd0, known_names[8], 16'h0000);
        queue_request(OP_READ, 3'd7, '0, 16'h0000);
        queue_request(OP_READ, 3'd0, '0, 16'h0000);
        queue_request(OP_READ, 3'd1, '0, 16'h0000);
        queue_request(OP_UNUSED, 3'd0, '0, 16'h0000);
        queue_request(OP_WRITE, 3'd3, with_trailing_noise(known_names[0]), 16'h1234);
        queue_request(OP_LOOKUP, 3'd0, known_names[1], 16'h0000);
        wait_for_drain();

        // Random phases: free flow, a sluggish sender, a sluggish receiver,
        // and both hesitating now and then.
        run_phase(0, 0, 240);
        run_phase(76, 0, 230);
        run_phase(0, 76, 230);
        run_phase(21, 21, 250);

        repeat (40) @(negedge i_clk);

        $display("Sent %0d requests; replies: %0d hits or updates, %0d inserts, %0d misses,",
                 accepted_count, hits, inserts, misses);
        $display("%0d writes dropped on a full table, %0d mismatches.", drops, mismatches);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("tb_keyed_record_slot_table passed");
        end else begin
            $display("tb_keyed_record_slot_table failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of the whole request list.
    initial begin
        #(4_000_000);
        $display("tb_keyed_record_slot_table failed");
        $finish;
    end

endmodule
